>>> rtl/idiv_pkg.sv
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared types for the integer divider: controller states and the command
// group that the controller drives into the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package idiv_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} idiv_state_t;

	typedef struct packed {
		logic load;   // capture operand magnitudes and signs
		logic step;   // one restoring-division iteration
		logic fixup;  // apply result signs and zero-divisor override
	} idiv_cmd_t;

endpackage

`default_nettype wire

>>> rtl/idiv_dp.sv
// ----------------------------------------------------------------------------
// idiv_dp
// Divider datapath: operand magnitude capture, radix-2 restoring iteration
// over a shared subtractor, and the final sign / zero-divisor fixup.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_dp #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  idiv_pkg::idiv_cmd_t     cmd,
	input  wire                     kind,
	input  wire  [DATA_WIDTH-1:0]   dividend,
	input  wire  [DATA_WIDTH-1:0]   divisor,
	output logic [DATA_WIDTH-1:0]   quotient,
	output logic [DATA_WIDTH-1:0]   remainder,
	output logic                    divide_by_zero
);

	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] div_q;
	logic                  q_neg_q;
	logic                  r_neg_q;
	logic                  dz_q;

	logic                  a_neg;
	logic                  b_neg;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [DATA_WIDTH:0]   partial;
	logic [DATA_WIDTH:0]   diff;

	assign a_neg = kind & dividend[DATA_WIDTH-1];
	assign b_neg = kind & divisor[DATA_WIDTH-1];
	// the minimum value negates to itself, which is its correct unsigned magnitude
	assign mag_a = a_neg ? (~dividend + 1'b1) : dividend;
	assign mag_b = b_neg ? (~divisor + 1'b1) : divisor;

	assign partial = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff    = partial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= 1'b0;
		end else if (cmd.load) begin
			dz_q <= (divisor == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q   <= mag_a;
			rem_q   <= '0;
			div_q   <= mag_b;
			q_neg_q <= a_neg ^ b_neg;
			r_neg_q <= a_neg;
		end else if (cmd.step) begin
			quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
			rem_q <= diff[DATA_WIDTH] ? partial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
		end else if (cmd.fixup) begin
			if (dz_q) begin
				quo_q <= '0;
				rem_q <= '0;
			end else begin
				quo_q <= q_neg_q ? (~quo_q + 1'b1) : quo_q;
				rem_q <= r_neg_q ? (~rem_q + 1'b1) : rem_q;
			end
		end
	end

	assign quotient       = quo_q;
	assign remainder      = rem_q;
	assign divide_by_zero = dz_q;

endmodule

`default_nettype wire

>>> rtl/idiv_ctrl.sv
// ----------------------------------------------------------------------------
// idiv_ctrl
// Divider controller: sequences load, DATA_WIDTH iterations, fixup and the
// one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	output logic                  done,
	output idiv_pkg::idiv_cmd_t   cmd
);

	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

	idiv_pkg::idiv_state_t state_q;
	idiv_pkg::idiv_state_t state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  accept;

	// a new beat may be taken in the cycle the previous result is shown
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			idiv_pkg::ST_IDLE: begin
				if (accept) state_d = idiv_pkg::ST_DIV;
			end
			idiv_pkg::ST_DIV: begin
				if (cnt_q == CNT_LAST) state_d = idiv_pkg::ST_FIX;
			end
			idiv_pkg::ST_FIX: begin
				state_d = idiv_pkg::ST_DONE;
			end
			idiv_pkg::ST_DONE: begin
				state_d = accept ? idiv_pkg::ST_DIV : idiv_pkg::ST_IDLE;
			end
			default: begin
				state_d = idiv_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b0;
		done      = 1'b0;
		cmd.load  = 1'b0;
		cmd.step  = 1'b0;
		cmd.fixup = 1'b0;
		case (state_q)
			idiv_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			idiv_pkg::ST_DIV: begin
				busy     = 1'b1;
				cmd.step = 1'b1;
			end
			idiv_pkg::ST_FIX: begin
				busy      = 1'b1;
				cmd.fixup = 1'b1;
			end
			idiv_pkg::ST_DONE: begin
				done     = 1'b1;
				cmd.load = start;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idiv_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == idiv_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == idiv_pkg::ST_DIV) && (cnt_q == '0))
		else $error("accepted beat did not start iteration");

	a_iter_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idiv_pkg::ST_DIV) && (cnt_q == CNT_LAST) |=> state_q == idiv_pkg::ST_FIX)
		else $error("iteration count overran");

	a_fix_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idiv_pkg::ST_FIX) |=> done)
		else $error("fixup not followed by result strobe");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.fixup}))
		else $error("conflicting datapath commands");

endmodule

`default_nettype wire

>>> rtl/int_divider_32.sv
// ----------------------------------------------------------------------------
// int_divider_32
// Sequential signed/unsigned integer divider with divide-by-zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind (0 unsigned, 1 signed), dividend and divisor with start high.
//   The beat is taken at a rising edge where start is high and busy is low.
//   DATA_WIDTH restoring iterations follow, one per cycle on a single
//   subtractor, then one sign fixup step; done then pulses for one cycle with
//   quotient, remainder and divide_by_zero valid. Busy stays high until
//   done, and a new beat can be taken in the done cycle.
//   Signed division truncates toward zero; the remainder follows the
//   dividend's sign. A zero divisor returns zero quotient and remainder with
//   divide_by_zero set. Minimum over minus one returns the minimum value.
//   The result must be captured in the done cycle; there is no backpressure.
//   Reset (arst_n low) returns the controller to idle with busy low.
// ----------------------------------------------------------------------------
`default_nettype none

module int_divider_32 #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire                     kind,
	input  wire  [DATA_WIDTH-1:0]   dividend,
	input  wire  [DATA_WIDTH-1:0]   divisor,
	output logic                    done,
	output logic [DATA_WIDTH-1:0]   quotient,
	output logic [DATA_WIDTH-1:0]   remainder,
	output logic                    divide_by_zero
);

	idiv_pkg::idiv_cmd_t cmd;

	idiv_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	idiv_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.kind           (kind),
		.dividend       (dividend),
		.divisor        (divisor),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_int_divider_32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_divider_32
// Self-checking bench for the sequential 32-bit signed/unsigned divider.
// A table of directed divisions comes first: extreme operands, zero divisors
// and the signed minimum over minus one. Random divisions follow under
// several sender idle patterns. Every result is checked against typed-in
// values or a behavioral divider kept in the bench.
// ----------------------------------------------------------------------------

module tb_int_divider_32;

	localparam int W           = 32;
	localparam int DIV_LATENCY = 34;
	localparam int IDLE_LIMIT  = 4000;
	localparam int RAND_ITEMS  = 1600;
	localparam int NUM_PHASES  = 3;

	localparam bit KIND_UNSIGNED = 1'b0;
	localparam bit KIND_SIGNED   = 1'b1;
	localparam bit EXP_PREDICT   = 1'b0;
	localparam bit EXP_TYPED     = 1'b1;

	typedef struct packed {
		logic [W-1:0] quo;
		logic [W-1:0] rem;
		logic         dbz;
	} div_result_t;

	typedef struct packed {
		logic         kind;
		logic [W-1:0] dvd;
		logic [W-1:0] dvs;
		logic         src;
		logic [W-1:0] quo;
		logic [W-1:0] rem;
		logic         dbz;
	} div_vector_t;

	localparam int NUM_DIRECTED = 25;

	// expected values typed in only where they are obvious
	localparam div_vector_t DIRECTED_TAB [NUM_DIRECTED] = '{
		'{KIND_UNSIGNED, 32'h0000_0000, 32'h0000_0001, EXP_TYPED, 32'h0, 32'h0, 1'b0},
		'{KIND_UNSIGNED, 32'h0000_0001, 32'h0000_0001, EXP_TYPED, 32'h1, 32'h0, 1'b0},
		'{KIND_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, EXP_TYPED, 32'hFFFF_FFFF, 32'h0, 1'b0},
		'{KIND_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_TYPED, 32'h1, 32'h0, 1'b0},
		'{KIND_UNSIGNED, 32'h0000_0001, 32'hFFFF_FFFF, EXP_TYPED, 32'h0, 32'h1, 1'b0},
		'{KIND_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0002, EXP_TYPED, 32'h7FFF_FFFF, 32'h1, 1'b0},
		'{KIND_UNSIGNED, 32'h8000_0000, 32'hFFFF_FFFF, EXP_TYPED, 32'h0, 32'h8000_0000, 1'b0},
		'{KIND_UNSIGNED, 32'h0000_0005, 32'h0000_0000, EXP_TYPED, 32'h0, 32'h0, 1'b1},
		'{KIND_UNSIGNED, 32'h0000_0000, 32'h0000_0000, EXP_TYPED, 32'h0, 32'h0, 1'b1},
		'{KIND_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, EXP_TYPED, 32'h0, 32'h0, 1'b1},
		'{KIND_UNSIGNED, 32'h0000_0064, 32'h0000_0007, EXP_PREDICT, 32'h0, 32'h0, 1'b0},
		'{KIND_UNSIGNED, 32'hDEAD_BEEF, 32'h0000_1234, EXP_PREDICT, 32'h0, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, EXP_TYPED, 32'h8000_0000, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h8000_0000, 32'h0000_0001, EXP_TYPED, 32'h8000_0000, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h8000_0000, 32'h8000_0000, EXP_TYPED, 32'h1, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, EXP_TYPED, 32'h0, 32'h7FFF_FFFF, 1'b0},
		'{KIND_SIGNED,   32'h7FFF_FFFF, 32'h7FFF_FFFF, EXP_TYPED, 32'h1, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'hFFFF_FFFF, 32'h0000_0000, EXP_TYPED, 32'h0, 32'h0, 1'b1},
		'{KIND_SIGNED,   32'h8000_0000, 32'h0000_0000, EXP_TYPED, 32'h0, 32'h0, 1'b1},
		'{KIND_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, EXP_PREDICT, 32'h0, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, EXP_PREDICT, 32'h0, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE, EXP_PREDICT, 32'h0, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h8000_0000, 32'h0000_0002, EXP_PREDICT, 32'h0, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'h0000_0000, 32'hFFFF_FFFF, EXP_TYPED, 32'h0, 32'h0, 1'b0},
		'{KIND_SIGNED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_TYPED, 32'h1, 32'h0, 1'b0}
	};

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic         kind;
	logic [W-1:0] dividend;
	logic [W-1:0] divisor;
	logic         done;
	logic [W-1:0] quotient;
	logic [W-1:0] remainder;
	logic         divide_by_zero;

	div_result_t pending_divs [$];

	int n_issued;
	int n_signed;
	int n_zero_div;
	int n_checked;
	int n_errors;
	int idle_cycles;

	int_divider_32 #(
		.DATA_WIDTH(W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.dividend      (dividend),
		.divisor       (divisor),
		.done          (done),
		.quotient      (quotient),
		.remainder     (remainder),
		.divide_by_zero(divide_by_zero)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// signed division runs on magnitudes; -min wraps to the 2^31 magnitude
	function automatic div_result_t compute_division(bit k, bit [W-1:0] a, bit [W-1:0] b);
		div_result_t res;
		bit          a_neg;
		bit          b_neg;
		bit [W-1:0]  mag_a;
		bit [W-1:0]  mag_b;
		bit [W-1:0]  mag_q;
		bit [W-1:0]  mag_r;
		res = '0;
		if (b == '0) begin
			res.dbz = 1'b1;
			return res;
		end
		if (k == KIND_UNSIGNED) begin
			res.quo = a / b;
			res.rem = a % b;
		end else begin
			a_neg = a[W-1];
			b_neg = b[W-1];
			mag_a = a_neg ? -a : a;
			mag_b = b_neg ? -b : b;
			mag_q = mag_a / mag_b;
			mag_r = mag_a % mag_b;
			res.quo = (a_neg ^ b_neg) ? -mag_q : mag_q;
			res.rem = a_neg ? -mag_r : mag_r;
		end
		return res;
	endfunction

	function automatic bit [W-1:0] rand_operand();
		bit [W-1:0] v;
		case ($urandom_range(0, 11))
			0: v = '0;
			1: v = 32'h0000_0001;
			2: v = 32'hFFFF_FFFF;
			3: v = 32'h8000_0000;
			4: v = 32'h7FFF_FFFF;
			5, 6, 7: v = $urandom;
			8, 9, 10: v = $urandom >> $urandom_range(1, 31);
			default: v = -($urandom >> $urandom_range(1, 31));
		endcase
		return v;
	endfunction

	// mostly short gaps, now and then a long one so start lands anywhere in a division
	function automatic int pick_gap(int pct);
		int n;
		n = 0;
		if (pct == 0)
			return 0;
		if ($urandom_range(0, 99) < 5)
			return $urandom_range(0, DIV_LATENCY + 6);
		while ($urandom_range(0, 99) < pct && n < 30)
			n++;
		return n;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic issue_division(bit k, bit [W-1:0] a, bit [W-1:0] b, bit src,
			div_result_t typed_res, int idle_pct);
		int          gap;
		div_result_t res;
		gap = pick_gap(idle_pct);
		for (int i = 0; i < gap; i++) begin
			start    <= 1'b0;
			kind     <= 1'($urandom_range(0, 1));
			dividend <= $urandom;
			divisor  <= $urandom;
			@(negedge clk);
		end
		start    <= 1'b1;
		kind     <= k;
		dividend <= a;
		divisor  <= b;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
		res = (src == EXP_TYPED) ? typed_res : compute_division(k, a, b);
		pending_divs.push_back(res);
		n_issued++;
		if (k == KIND_SIGNED)
			n_signed++;
		if (b == '0)
			n_zero_div++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_divs.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		div_result_t typed_res;
		int          phase_pct [NUM_PHASES];
		phase_pct = '{0, 53, 7};
		n_issued   = 0;
		n_signed   = 0;
		n_zero_div = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		kind     = 1'b0;
		dividend = '0;
		divisor  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_TAB[i]) begin
			typed_res = '{DIRECTED_TAB[i].quo, DIRECTED_TAB[i].rem, DIRECTED_TAB[i].dbz};
			issue_division(DIRECTED_TAB[i].kind, DIRECTED_TAB[i].dvd, DIRECTED_TAB[i].dvs,
				DIRECTED_TAB[i].src, typed_res, 0);
		end
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int i = 0; i < RAND_ITEMS / NUM_PHASES; i++)
				issue_division(1'($urandom_range(0, 1)), rand_operand(), rand_operand(),
					EXP_PREDICT, '0, phase_pct[p]);
			// hold off until the pipe is empty between idle patterns
			drain_results();
		end

		repeat (2 * DIV_LATENCY) @(negedge clk);
		$display("Summary: %0d divisions issued, %0d signed, %0d with zero divisor",
			n_issued, n_signed, n_zero_div);
		$display("Summary: %0d results compared, %0d mismatches, sender idle 0/53/7 pct",
			n_checked, n_errors);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// result checker: one beat per done cycle, no backpressure
	initial begin
		n_checked = 0;
		n_errors  = 0;
	end

	always @(posedge clk) begin
		div_result_t exp_res;
		if (arst_n && done === 1'b1) begin
			if (pending_divs.size() == 0) begin
				$error("unexpected result beat: quotient %h remainder %h divide_by_zero %b",
					quotient, remainder, divide_by_zero);
				n_errors++;
			end else begin
				exp_res = pending_divs.pop_front();
				n_checked++;
				if (quotient !== exp_res.quo) begin
					$error("quotient mismatch: expected %h, actual %h", exp_res.quo, quotient);
					n_errors++;
				end
				if (remainder !== exp_res.rem) begin
					$error("remainder mismatch: expected %h, actual %h", exp_res.rem, remainder);
					n_errors++;
				end
				if (divide_by_zero !== exp_res.dbz) begin
					$error("divide_by_zero mismatch: expected %b, actual %b",
						exp_res.dbz, divide_by_zero);
					n_errors++;
				end
			end
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

endmodule

>>> int_divider_32.f
rtl/idiv_pkg.sv
rtl/idiv_dp.sv
rtl/idiv_ctrl.sv
rtl/int_divider_32.sv
tb/sv/tb_int_divider_32.sv
